// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every rising clock edge outside reset.
`define KMSD_ASSERT_ALWAYS(name, clk, rstn, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define KMSD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kmsd_pkg.sv =====
`default_nettype none
package kmsd_pkg;
    localparam int CNT_W     = 4;
    localparam int LEVEL_W   = 4;
    localparam int ROW_OUT_W = 3;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd5;
endpackage
`default_nettype wire

// ===== rtl/kmsd_counter_ram.sv =====
`default_nettype none
module kmsd_counter_ram import kmsd_pkg::*; #(
    parameter int DEPTH  = 5,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] mem_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             hit_valid_reg;
    logic             fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits stand in for a cleared memory; a write in flight to the read row is forwarded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            hit_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_valid_reg <= row_valid_reg[rd_addr];
                fwd_reg       <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (hit_valid_reg ? mem_q_reg : '0);
endmodule
`default_nettype wire

// ===== rtl/kmsd_update.sv =====
`default_nettype none
module kmsd_update import kmsd_pkg::*; #(
    parameter int COLUMNS = 4
) (
    input  wire logic [COLUMNS*CNT_W-1:0] counters_in,
    input  wire logic [COLUMNS-1:0]       pressed,
    input  wire logic [CNT_W-1:0]         limit,
    output logic      [COLUMNS*CNT_W-1:0] counters_out,
    output logic      [COLUMNS-1:0]       press,
    output logic      [COLUMNS-1:0]       release_hit
);
    // Integrate each key independently: up while pressed, down while released.
    always_comb begin
        logic [CNT_W-1:0] c;
        counters_out = counters_in;
        press        = '0;
        release_hit  = '0;
        for (int j = 0; j < COLUMNS; j++) begin
            c = counters_in[j*CNT_W +: CNT_W];
            if (pressed[j]) begin
                if (c < limit) begin
                    c        = c + CNT_W'(1);
                    press[j] = (c == limit);
                end
            end else if (c != '0) begin
                release_hit[j] = (c == CNT_W'(1));
                c              = c - CNT_W'(1);
            end
            counters_out[j*CNT_W +: CNT_W] = c;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/key_matrix_scan_debounce.sv =====
`default_nettype none
// Key matrix scanner with per-key integrator debounce. Each input transaction carries the
// column levels sampled while the current row was driven; the block updates one saturating
// 4-bit counter per key of that row and returns one result transaction naming the scanned
// row, the keys that just reached the debounce limit (press), the keys that just fell back
// to zero (release) and the next row to drive. The counters of a row sit together in one
// word of a small synchronous memory: a transaction reads its row on acceptance, the update
// is computed the cycle after and written back as the result is registered. A write to the
// row being read in the same cycle is forwarded, so a new transaction is taken every cycle
// while the output takes results. Reset clears all counters at once through
// per-row valid bits; no clearing pass is needed. cfg_wr_en/cfg_wr_data set debounce_limit
// (reset value 5), to be written only while the block is idle.
`include "assert_macros.svh"
module key_matrix_scan_debounce import kmsd_pkg::*; #(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CNT_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [LEVEL_W-1:0]   s_column_levels,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [ROW_OUT_W-1:0] m_scanned_row,
    output logic      [LEVEL_W-1:0]   m_press_mask,
    output logic      [LEVEL_W-1:0]   m_release_mask,
    output logic      [ROW_OUT_W-1:0] m_next_row
);
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WORD_W = COLUMNS * CNT_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [CNT_W-1:0]   debounce_limit_reg;
    logic [RW-1:0]      row_index_reg;
    logic [RW-1:0]      row_index_next;
    logic               s1_valid_reg;
    logic [RW-1:0]      s1_row_reg;
    logic [LEVEL_W-1:0] s1_levels_reg;
    logic               s1_advance;
    logic               in_accept;
    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  wr_word;
    logic [COLUMNS-1:0] pressed;
    logic [COLUMNS-1:0] press_full;
    logic [COLUMNS-1:0] release_full;
    logic [RW-1:0]      s1_next_row;

    logic                 m_valid_reg;
    logic [ROW_OUT_W-1:0] m_scanned_row_reg;
    logic [LEVEL_W-1:0]   m_press_mask_reg;
    logic [LEVEL_W-1:0]   m_release_mask_reg;
    logic [ROW_OUT_W-1:0] m_next_row_reg;

    // Stage 1 drains into the output register whenever that register is free or being taken.
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign in_accept  = s_valid && s_ready;

    assign row_index_next = (row_index_reg == LAST_ROW) ? '0 : row_index_reg + RW'(1);
    assign s1_next_row    = (s1_row_reg == LAST_ROW) ? '0 : s1_row_reg + RW'(1);

    // Columns beyond the sampled width read as released.
    assign pressed = COLUMNS'(s1_levels_reg);

    kmsd_counter_ram #(
        .DEPTH  (ROWS),
        .WIDTH  (WORD_W),
        .ADDR_W (RW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (row_index_reg),
        .rd_data (rd_word),
        .wr_en   (s1_advance),
        .wr_addr (s1_row_reg),
        .wr_data (wr_word)
    );

    kmsd_update #(
        .COLUMNS (COLUMNS)
    ) u_update (
        .counters_in  (rd_word),
        .pressed      (pressed),
        .limit        (debounce_limit_reg),
        .counters_out (wr_word),
        .press        (press_full),
        .release_hit  (release_full)
    );

    // Control state: limit, row pointer, stage and output valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= LIMIT_RESET;
            row_index_reg      <= '0;
            s1_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                debounce_limit_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                row_index_reg <= row_index_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the transaction on acceptance, the result on stage 1 advance.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_row_reg    <= row_index_reg;
            s1_levels_reg <= s_column_levels;
        end
        if (s1_advance) begin
            m_scanned_row_reg  <= ROW_OUT_W'(s1_row_reg);
            m_press_mask_reg   <= LEVEL_W'(press_full);
            m_release_mask_reg <= LEVEL_W'(release_full);
            m_next_row_reg     <= ROW_OUT_W'(s1_next_row);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scanned_row  = m_scanned_row_reg;
    assign m_press_mask   = m_press_mask_reg;
    assign m_release_mask = m_release_mask_reg;
    assign m_next_row     = m_next_row_reg;

    `KMSD_ASSERT_ALWAYS(a_row_in_range, aclk, aresetn, row_index_reg <= LAST_ROW, "row pointer out of range")
    `KMSD_ASSERT_ALWAYS(a_masks_disjoint, aclk, aresetn, !m_valid || ((m_press_mask & m_release_mask) == '0), "key both pressed and released")
    `KMSD_ASSERT_NEXT(a_stall_holds, aclk, aresetn, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_row_reg), "stalled stage lost its transaction")
    `KMSD_ASSERT_NEXT(a_row_steps, aclk, aresetn, in_accept, row_index_reg == $past(row_index_next), "row pointer did not advance")
endmodule
`default_nettype wire

// ===== sim/key_scan_checker.sv =====
module key_scan_checker import kmsd_pkg::*; #(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [LEVEL_W-1:0]   s_column_levels,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [ROW_OUT_W-1:0] m_scanned_row,
    input  logic [LEVEL_W-1:0]   m_press_mask,
    input  logic [LEVEL_W-1:0]   m_release_mask,
    input  logic [ROW_OUT_W-1:0] m_next_row,
    output int                   outstanding,
    output int                   fail_count
);

    typedef struct packed {
        logic [ROW_OUT_W-1:0] scanned_row;
        logic [LEVEL_W-1:0]   press_mask;
        logic [LEVEL_W-1:0]   release_mask;
        logic [ROW_OUT_W-1:0] next_row;
    } scan_report_t;

    logic [CNT_W-1:0] limit_q;
    int unsigned      row_q;
    logic [CNT_W-1:0] key_count [ROWS*COLUMNS];
    scan_report_t     awaited_reports [$];
    int               mismatches = 0;

    assign fail_count = mismatches;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Integrate one row of keys and advance the row pointer.
    function automatic scan_report_t debounce_row(input logic [LEVEL_W-1:0] levels);
        scan_report_t     rep;
        int unsigned      row;
        int unsigned      nxt;
        logic [CNT_W-1:0] c;
        logic             down;
        rep = '0;
        row = (row_q >= ROWS) ? 0 : row_q;
        for (int j = 0; j < COLUMNS; j++) begin
            c    = key_count[row*COLUMNS + j];
            down = (j < LEVEL_W) ? levels[j] : 1'b0;
            if (down) begin
                // Saturate at the limit; a counter above it just holds.
                if (c < limit_q) begin
                    c = c + 1'b1;
                    if (c == limit_q && j < LEVEL_W) rep.press_mask[j] = 1'b1;
                end
            end else if (c != '0) begin
                c = c - 1'b1;
                if (c == '0 && j < LEVEL_W) rep.release_mask[j] = 1'b1;
            end
            key_count[row*COLUMNS + j] = c;
        end
        nxt             = (row + 1 >= ROWS) ? 0 : row + 1;
        row_q           = nxt;
        rep.scanned_row = ROW_OUT_W'(row);
        rep.next_row    = ROW_OUT_W'(nxt);
        return rep;
    endfunction

    always @(posedge aclk) begin : watch
        scan_report_t want;
        if (!aresetn) begin
            limit_q = LIMIT_RESET;
            row_q   = 0;
            foreach (key_count[i]) key_count[i] = '0;
            awaited_reports.delete();
        end else begin
            if (cfg_wr_en) limit_q = cfg_wr_data;
            if (s_valid && s_ready) awaited_reports.push_back(debounce_row(s_column_levels));
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    flag_mismatch("unawaited result, scanned_row", m_scanned_row, -1);
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_scanned_row !== want.scanned_row)
                        flag_mismatch("scanned_row", m_scanned_row, want.scanned_row);
                    if (m_press_mask !== want.press_mask)
                        flag_mismatch("press_mask", m_press_mask, want.press_mask);
                    if (m_release_mask !== want.release_mask)
                        flag_mismatch("release_mask", m_release_mask, want.release_mask);
                    if (m_next_row !== want.next_row)
                        flag_mismatch("next_row", m_next_row, want.next_row);
                end
            end
        end
        outstanding <= awaited_reports.size();
    end

endmodule

// ===== sim/tb_key_matrix_scan_debounce.sv =====
module tb_key_matrix_scan_debounce;
    import kmsd_pkg::*;

    localparam int ROWS            = 5;
    localparam int COLUMNS         = 4;
    localparam int MAX_GAP         = 5;
    // Longest run of cycles with no transaction on either channel before giving up.
    // The receiver's hold-off is the longest legitimate quiet stretch.
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Extra wait after the last awaited result has drained.
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 160;
    localparam int PHASE_COUNT     = 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CNT_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [LEVEL_W-1:0]   s_column_levels;
    logic                 m_valid;
    logic                 m_ready;
    logic [ROW_OUT_W-1:0] m_scanned_row;
    logic [LEVEL_W-1:0]   m_press_mask;
    logic [LEVEL_W-1:0]   m_release_mask;
    logic [ROW_OUT_W-1:0] m_next_row;

    int outstanding;
    int fail_count;
    int idle_cycles = 0;

    // Sender side state: the physical key positions per row, and the row the
    // block will scan with the next transaction.
    logic [LEVEL_W-1:0] held_keys [ROWS];
    int unsigned        next_scan_row;
    logic               send_burst;

    key_matrix_scan_debounce #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scanned_row   (m_scanned_row),
        .m_press_mask    (m_press_mask),
        .m_release_mask  (m_release_mask),
        .m_next_row      (m_next_row)
    );

    key_scan_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) scan_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scanned_row   (m_scanned_row),
        .m_press_mask    (m_press_mask),
        .m_release_mask  (m_release_mask),
        .m_next_row      (m_next_row),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: restart the count on every transaction, give up when the
    // block has gone quiet for far longer than any correct run allows.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one row sample after a random gap (none in a burst) and hold it until taken.
    // Valid is left high afterwards so back-to-back transactions need no
    // second assignment in the same step.
    task automatic send_scan(input logic [LEVEL_W-1:0] levels);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_column_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        next_scan_row = (next_scan_row + 1) % ROWS;
    endtask

    // Drop valid, let every awaited result drain, then set a new limit.
    task automatic write_limit(input logic [CNT_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Model a human on the keypad: keys of the row about to be scanned stay
    // put for a while, toggling less often the higher the limit so presses
    // still get through. Add contact bounce on top, and now and then send
    // pure noise for the row.
    function automatic logic [LEVEL_W-1:0] draw_levels(input int unsigned limit);
        logic [LEVEL_W-1:0] levels;
        for (int j = 0; j < LEVEL_W; j++)
            if ($urandom_range(0, 2*limit + 5) == 0)
                held_keys[next_scan_row][j] = ~held_keys[next_scan_row][j];
        if ($urandom_range(0, 11) == 0) return LEVEL_W'($urandom_range(0, 15));
        levels = held_keys[next_scan_row];
        for (int j = 0; j < LEVEL_W; j++)
            if ($urandom_range(0, 9) == 0) levels[j] = ~levels[j];
        return levels;
    endfunction

    // Result sink: random stalls per transaction, stretches of full speed,
    // and two long hold-offs so the block backs up and drops s_ready.
    initial begin : result_sink
        int stall;
        int results_taken;
        logic take_burst;
        results_taken = 0;
        take_burst    = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0) take_burst = ($urandom_range(0, 3) == 0);
            if (results_taken == 700 || results_taken == 1500)
                stall = HOLD_OFF_CYCLES;
            else
                stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] limits [PHASE_COUNT];
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        s_valid         <= 1'b0;
        s_column_levels <= '0;
        send_burst    = 1'b0;
        next_scan_row = 0;
        foreach (held_keys[r]) held_keys[r] = '0;

        // Start high, then lower the limit under held keys so counters sit
        // above it; visit a limit of zero and both ends of the range.
        limits = '{4'd15, 4'd4, 4'd0, 4'd9, 4'd1, 4'd15, 4'd7, 4'd3,
                   4'd0, 4'd12, 4'd0, 4'd2};
        limits[8]  = CNT_W'($urandom_range(1, 14));
        limits[10] = CNT_W'($urandom_range(0, 15));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: an idle sweep at the reset limit, then with a limit of
        // one every key presses at once; swap halves of the row to press one
        // half while releasing the other, and finally release everything.
        repeat (ROWS) send_scan('0);
        write_limit(4'd1);
        repeat (ROWS) send_scan(4'hF);
        repeat (ROWS) send_scan(4'hA);
        repeat (ROWS) send_scan(4'h5);
        repeat (ROWS) send_scan(4'h0);

        // Random phases, one limit each; some phases run without gaps.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_limit(limits[p]);
            send_burst = ($urandom_range(0, 2) == 0);
            repeat (PHASE_ITEMS) send_scan(draw_levels(limits[p]));
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== key_matrix_scan_debounce.f =====
+incdir+rtl
rtl/kmsd_pkg.sv
rtl/kmsd_counter_ram.sv
rtl/kmsd_update.sv
rtl/key_matrix_scan_debounce.sv
sim/key_scan_checker.sv
sim/tb_key_matrix_scan_debounce.sv
